>>> rtl/gnss_binary_frame_checker_unit_assert.svh
// Assertion macros shared by the frame checker modules.
// GBFC_ASSERT_CK takes an explicit clock and active-low reset.
// GBFC_ASSERT uses clk_i and rst_ni of the enclosing module.
`ifndef GNSS_BINARY_FRAME_CHECKER_UNIT_ASSERT_SVH
`define GNSS_BINARY_FRAME_CHECKER_UNIT_ASSERT_SVH

`ifndef SYNTH

`define GBFC_ASSERT_CK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define GBFC_ASSERT(label, prop, msg) \
  `GBFC_ASSERT_CK(label, clk_i, rst_ni, prop, msg)

`else

`define GBFC_ASSERT_CK(label, clk, rst_n, prop, msg)

`define GBFC_ASSERT(label, prop, msg)

`endif

`endif

>>> rtl/gbfc_pkg.sv
package gbfc_pkg;

  localparam int unsigned CountW = 17;

  // Frame framing bytes
  localparam logic [7:0] SyncFirst  = 8'hB5;
  localparam logic [7:0] SyncSecond = 8'h62;
  localparam logic [7:0] AckClass   = 8'h05;
  localparam logic [7:0] AckIdAck   = 8'h01;
  localparam logic [7:0] AckIdNack  = 8'h00;

  localparam logic [CountW-1:0] CountMax      = 17'h1FFFF;
  localparam logic [CountW-1:0] FrameOverhead = 17'd8;
  localparam logic [CountW-1:0] AckMinBytes   = 17'd4;
  localparam logic [CountW-1:0] SumStartPos   = 17'd4;

  // Byte positions inside a frame
  localparam logic [CountW-1:0] PosSync0 = 17'd0;
  localparam logic [CountW-1:0] PosSync1 = 17'd1;
  localparam logic [CountW-1:0] PosClass = 17'd2;
  localparam logic [CountW-1:0] PosId    = 17'd3;
  localparam logic [CountW-1:0] PosLenLo = 17'd4;
  localparam logic [CountW-1:0] PosLenHi = 17'd5;
  localparam logic [CountW-1:0] PosEcho0 = 17'd6;
  localparam logic [CountW-1:0] PosEcho1 = 17'd7;

  // Mismatch flag bits
  localparam int unsigned FlagSync = 0;
  localparam int unsigned FlagAck  = 1;
  localparam int unsigned FlagExp  = 2;
  localparam int unsigned FlagEcho = 3;

  // Configuration register indexes
  localparam logic [1:0] RegExpClass = 2'd0;
  localparam logic [1:0] RegExpId    = 2'd1;
  localparam logic [1:0] RegAckMode  = 2'd2;

  typedef enum logic [1:0] {
    StatusOk    = 2'd0,
    StatusError = 2'd1,
    StatusShort = 2'd2
  } status_e;

  typedef struct packed {
    logic [7:0] exp_class;
    logic [7:0] exp_id;
    logic       ack_mode;
  } cfg_t;

  typedef struct packed {
    logic [CountW-1:0] count;
    logic [7:0]        sum_a;
    logic [7:0]        sum_b;
    logic [15:0]       last_two;
    logic [15:0]       pay_len;
    logic [3:0]        flags;
    logic [7:0]        id_seen;
  } frame_t;

endpackage

>>> rtl/gbfc_frame_state.sv
`include "gnss_binary_frame_checker_unit_assert.svh"

module gbfc_frame_state import gbfc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       xfer_i,
  input  logic [7:0] frame_byte_i,
  input  logic       final_byte_i,
  input  cfg_t       cfg_i,
  output frame_t     frame_o
);

  frame_t frame_q, frame_d;

  // Fold the incoming byte into the running frame state
  always_comb begin
    frame_d = frame_q;
    unique case (frame_q.count)
      PosSync0: begin
        if (frame_byte_i != SyncFirst) frame_d.flags[FlagSync] = 1'b1;
      end
      PosSync1: begin
        if (frame_byte_i != SyncSecond) frame_d.flags[FlagSync] = 1'b1;
      end
      PosClass: begin
        if (frame_byte_i != AckClass) frame_d.flags[FlagAck] = 1'b1;
        if (frame_byte_i != cfg_i.exp_class) frame_d.flags[FlagExp] = 1'b1;
      end
      PosId: begin
        frame_d.id_seen = frame_byte_i;
        if (frame_byte_i != AckIdAck) frame_d.flags[FlagAck] = 1'b1;
        if (frame_byte_i != cfg_i.exp_id) frame_d.flags[FlagExp] = 1'b1;
      end
      PosLenLo: begin
        frame_d.pay_len[7:0] = frame_byte_i;
      end
      PosLenHi: begin
        frame_d.pay_len[15:8] = frame_byte_i;
      end
      PosEcho0: begin
        if (frame_byte_i != cfg_i.exp_class) frame_d.flags[FlagEcho] = 1'b1;
      end
      PosEcho1: begin
        if (frame_byte_i != cfg_i.exp_id) frame_d.flags[FlagEcho] = 1'b1;
      end
      default: begin
      end
    endcase

    // Add each byte two positions late, once it cannot be a check byte
    if (frame_q.count >= SumStartPos) begin
      frame_d.sum_a = frame_q.sum_a + frame_q.last_two[15:8];
      frame_d.sum_b = frame_q.sum_b + frame_d.sum_a;
    end
    frame_d.last_two = {frame_q.last_two[7:0], frame_byte_i};
    if (frame_q.count < CountMax) begin
      frame_d.count = frame_q.count + 1'b1;
    end
  end

  // Hold state between transfers, clear after the final byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_q <= '0;
    end else if (xfer_i) begin
      if (final_byte_i) begin
        frame_q <= '0;
      end else begin
        frame_q <= frame_d;
      end
    end
  end

  assign frame_o = frame_d;

  `GBFC_ASSERT(a_count_advances, xfer_i && !final_byte_i |=> frame_q.count != '0,
               "byte count did not advance on a non-final byte")
  `GBFC_ASSERT(a_final_clears, xfer_i && final_byte_i |=> frame_q.count == '0 &&
               frame_q.flags == '0, "frame state not cleared after final byte")
  `GBFC_ASSERT(a_sums_idle_early, frame_q.count < SumStartPos |->
               frame_q.sum_a == '0 && frame_q.sum_b == '0,
               "checksum accumulated before the length field")

endmodule

>>> rtl/gbfc_judge.sv
module gbfc_judge import gbfc_pkg::*; #(
  parameter int unsigned MAX_PAYLOAD = 1024
) (
  input  frame_t  frame_i,
  input  logic    ack_mode_i,
  output status_e status_o
);

  localparam logic [CountW-1:0] MaxPayload = CountW'(MAX_PAYLOAD);

  logic [CountW-1:0] len_ext;
  logic              hdr_bad;
  logic              packet_ok;

  assign len_ext = {1'b0, frame_i.pay_len};
  assign hdr_bad = ack_mode_i ? frame_i.flags[FlagAck] : frame_i.flags[FlagExp];

  // Combine framing, length and checksum checks
  assign packet_ok = !frame_i.flags[FlagSync] && !hdr_bad
                  && (len_ext <= MaxPayload)
                  && (frame_i.count == FrameOverhead + len_ext)
                  && (frame_i.sum_a == frame_i.last_two[15:8])
                  && (frame_i.sum_b == frame_i.last_two[7:0]);

  // Pick the status, short frames first
  always_comb begin
    priority if (frame_i.count < FrameOverhead) begin
      if (ack_mode_i && frame_i.count >= AckMinBytes && frame_i.id_seen == AckIdNack) begin
        status_o = StatusError;
      end else begin
        status_o = StatusShort;
      end
    end else if (!packet_ok) begin
      status_o = StatusError;
    end else if (ack_mode_i && frame_i.flags[FlagEcho]) begin
      status_o = StatusError;
    end else begin
      status_o = StatusOk;
    end
  end

endmodule

>>> rtl/gnss_binary_frame_checker_unit.sv
// Binary GNSS frame checker.
// Input channel: one frame byte per transfer (frame_byte_i), with final_byte_i
// marking the last byte of a frame. Output channel: one check_status_o per
// frame, 0 ok, 1 frame error or negative acknowledge, 2 frame too short.
// Configuration: cfg_we_i writes cfg_wdata_i into register cfg_index_i
// (0 expected class, 1 expected id, 2 ack mode); index 3 is ignored.
// Throughput: one byte per cycle while the output is not stalled. Every byte is
// folded into the frame state in the cycle of its transfer; the status of the final
// byte is computed in that same cycle and lands in the output register, so it is
// visible in the cycle after the final byte transfer.
// The single output register decides the rate under stall: while a status
// waits and out_ready_i is low, in_ready_o is low and no byte is taken; when
// the status is taken, a new byte may transfer in that same cycle.
// Reset clears the frame state, the configuration registers and the output
// valid flag; the first byte after reset starts a new frame.
`include "gnss_binary_frame_checker_unit_assert.svh"

module gnss_binary_frame_checker_unit import gbfc_pkg::*; #(
  parameter int unsigned MAX_PAYLOAD = 1024
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] frame_byte_i,
  input  logic       final_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [1:0] check_status_o,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_index_i,
  input  logic [7:0] cfg_wdata_i
);

  cfg_t    cfg_q;
  frame_t  frame_next;
  status_e status_d;
  status_e status_q;
  logic    out_valid_q, out_valid_d;
  logic    in_xfer;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_xfer    = in_valid_i && in_ready_o;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        RegExpClass: cfg_q.exp_class <= cfg_wdata_i;
        RegExpId:    cfg_q.exp_id    <= cfg_wdata_i;
        RegAckMode:  cfg_q.ack_mode  <= cfg_wdata_i[0];
        default: begin
        end
      endcase
    end
  end

  gbfc_frame_state u_frame_state (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .xfer_i       (in_xfer),
    .frame_byte_i (frame_byte_i),
    .final_byte_i (final_byte_i),
    .cfg_i        (cfg_q),
    .frame_o      (frame_next)
  );

  gbfc_judge #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_judge (
    .frame_i    (frame_next),
    .ack_mode_i (cfg_q.ack_mode),
    .status_o   (status_d)
  );

  // Load a status on the final byte, drop valid once it is taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (in_xfer && final_byte_i) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer && final_byte_i) begin
      status_q <= status_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign check_status_o = status_q;

  `GBFC_ASSERT(a_result_from_final, $rose(out_valid_o) |->
               $past(in_valid_i && in_ready_o && final_byte_i),
               "status raised without a final byte transfer")
  `GBFC_ASSERT(a_long_not_short, in_xfer && final_byte_i &&
               frame_next.count >= FrameOverhead |=> check_status_o != StatusShort,
               "frame of full size reported as too short")
  `GBFC_ASSERT(a_pending_kept, out_valid_o && !out_ready_i |=> out_valid_o,
               "pending status lost while stalled")

endmodule

>>> tb/gnss_frame_status_checker.sv
module gnss_frame_status_checker import gbfc_pkg::*; #(
  parameter int unsigned MAX_PAYLOAD = 1024
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_ready_i,
  input  logic [7:0] frame_byte_i,
  input  logic       final_byte_i,
  input  logic       out_valid_i,
  input  logic       out_ready_i,
  input  logic [1:0] check_status_i,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_index_i,
  input  logic [7:0] cfg_wdata_i,
  output int         mismatch_count_o,
  output int         pending_o,
  output int         ok_count_o,
  output int         error_count_o,
  output int         short_count_o
);

  cfg_t    cfg;
  frame_t  frm;
  status_e status_due_q[$];
  status_e want;
  int      mismatches;
  int      ok_seen;
  int      error_seen;
  int      short_seen;

  // Fold one byte into the running frame state
  function automatic frame_t fold_frame_byte(frame_t f, cfg_t c, logic [7:0] b);
    case (f.count)
      PosSync0: if (b != SyncFirst) f.flags[FlagSync] = 1'b1;
      PosSync1: if (b != SyncSecond) f.flags[FlagSync] = 1'b1;
      PosClass: begin
        if (b != AckClass) f.flags[FlagAck] = 1'b1;
        if (b != c.exp_class) f.flags[FlagExp] = 1'b1;
      end
      PosId: begin
        f.id_seen = b;
        if (b != AckIdAck) f.flags[FlagAck] = 1'b1;
        if (b != c.exp_id) f.flags[FlagExp] = 1'b1;
      end
      PosLenLo: f.pay_len[7:0] = b;
      PosLenHi: f.pay_len[15:8] = b;
      PosEcho0: if (b != c.exp_class) f.flags[FlagEcho] = 1'b1;
      PosEcho1: if (b != c.exp_id) f.flags[FlagEcho] = 1'b1;
      default: ;
    endcase
    // Sum each byte two positions late, once it cannot be a check byte
    if (f.count >= SumStartPos) begin
      f.sum_a = f.sum_a + f.last_two[15:8];
      f.sum_b = f.sum_b + f.sum_a;
    end
    f.last_two = {f.last_two[7:0], b};
    if (f.count != CountMax) f.count = f.count + 1'b1;
    return f;
  endfunction

  // Judge a closed frame
  function automatic status_e frame_status(frame_t f, cfg_t c);
    int unsigned hdr_flag;
    logic        good;
    hdr_flag = c.ack_mode ? FlagAck : FlagExp;
    if (f.count < FrameOverhead) begin
      if (c.ack_mode && f.count >= AckMinBytes && f.id_seen == AckIdNack) return StatusError;
      return StatusShort;
    end
    good = !f.flags[FlagSync] && !f.flags[hdr_flag]
        && (f.pay_len <= MAX_PAYLOAD)
        && (f.count == FrameOverhead + CountW'(f.pay_len))
        && (f.sum_a == f.last_two[15:8])
        && (f.sum_b == f.last_two[7:0]);
    if (!good) return StatusError;
    if (c.ack_mode && f.flags[FlagEcho]) return StatusError;
    return StatusOk;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg = '0;
      frm = '0;
      status_due_q.delete();
      mismatches = 0;
      ok_seen = 0;
      error_seen = 0;
      short_seen = 0;
    end else begin
      // Compare each status transfer with the oldest frame still due
      if (out_valid_i && out_ready_i) begin
        if (status_due_q.size() == 0) begin
          $error("check_status: expected none, actual %0d", check_status_i);
          mismatches++;
        end else begin
          want = status_due_q.pop_front();
          if (check_status_i !== want) begin
            $error("check_status: expected %0d, actual %0d", want, check_status_i);
            mismatches++;
          end
          case (want)
            StatusOk:    ok_seen++;
            StatusError: error_seen++;
            default:     short_seen++;
          endcase
        end
      end
      // Advance the frame on each byte transfer; close it on the final byte
      if (in_valid_i && in_ready_i) begin
        frm = fold_frame_byte(frm, cfg, frame_byte_i);
        if (final_byte_i) begin
          status_due_q.push_back(frame_status(frm, cfg));
          frm = '0;
        end
      end
      // Register writes land after the byte of the same edge is folded
      if (cfg_we_i) begin
        case (cfg_index_i)
          RegExpClass: cfg.exp_class = cfg_wdata_i;
          RegExpId:    cfg.exp_id = cfg_wdata_i;
          RegAckMode:  cfg.ack_mode = cfg_wdata_i[0];
          default: ;
        endcase
      end
    end
    mismatch_count_o <= mismatches;
    pending_o <= status_due_q.size();
    ok_count_o <= ok_seen;
    error_count_o <= error_seen;
    short_count_o <= short_seen;
  end

endmodule

>>> tb/tb_gnss_binary_frame_checker_unit.sv
module tb_gnss_binary_frame_checker_unit;
  import gbfc_pkg::*;

  localparam int unsigned MaxPay = 1024;
  localparam logic [1:0] RegUnused = 2'd3;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_ready_o;
  logic [7:0] frame_byte_i = 8'd0;
  logic       final_byte_i = 1'b0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic [1:0] check_status_o;
  logic       cfg_we_i = 1'b0;
  logic [1:0] cfg_index_i = 2'd0;
  logic [7:0] cfg_wdata_i = 8'd0;

  int mismatch_count;
  int pending;
  int ok_count;
  int error_count;
  int short_count;

  int         snd_idle = 0;
  int         rcv_stall = 0;
  int         bytes_sent = 0;
  int         frames_sent = 0;
  int         settings_used = 0;
  logic [7:0] frame_q[$];
  logic [7:0] cur_cls = 8'd0;
  logic [7:0] cur_id = 8'd0;
  logic       cur_ack = 1'b0;

  gnss_binary_frame_checker_unit #(.MAX_PAYLOAD(MaxPay)) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .frame_byte_i  (frame_byte_i),
    .final_byte_i  (final_byte_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .check_status_o(check_status_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  gnss_frame_status_checker #(.MAX_PAYLOAD(MaxPay)) u_status_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_i      (in_ready_o),
    .frame_byte_i    (frame_byte_i),
    .final_byte_i    (final_byte_i),
    .out_valid_i     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .check_status_i  (check_status_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .mismatch_count_o(mismatch_count),
    .pending_o       (pending),
    .ok_count_o      (ok_count),
    .error_count_o   (error_count),
    .short_count_o   (short_count)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Stall the status channel at the rate of the current phase
  always @(posedge clk_i) begin
    out_ready_i <= rst_ni && ($urandom_range(99) >= rcv_stall);
  end

  // Offer one byte, idling first at the current rate, and hold it until taken
  task automatic put_byte(input logic [7:0] b, input logic fin);
    while ($urandom_range(99) < snd_idle) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    frame_byte_i <= b;
    final_byte_i <= fin;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    bytes_sent++;
  endtask

  task automatic send_frame();
    int k;
    for (k = 0; k < frame_q.size(); k++) put_byte(frame_q[k], k == frame_q.size() - 1);
    frames_sent++;
  endtask

  task automatic start_frame(input logic [7:0] cls, input logic [7:0] id,
                             input logic [15:0] len);
    frame_q.delete();
    frame_q.push_back(SyncFirst);
    frame_q.push_back(SyncSecond);
    frame_q.push_back(cls);
    frame_q.push_back(id);
    frame_q.push_back(len[7:0]);
    frame_q.push_back(len[15:8]);
  endtask

  // Append the two check bytes over class through payload
  task automatic add_sums();
    logic [7:0] a;
    logic [7:0] b;
    int         k;
    a = 8'd0;
    b = 8'd0;
    for (k = 2; k < frame_q.size(); k++) begin
      a = a + frame_q[k];
      b = b + a;
    end
    frame_q.push_back(a);
    frame_q.push_back(b);
  endtask

  task automatic build_frame(input logic [7:0] cls, input logic [7:0] id, input int npay);
    start_frame(cls, id, 16'(npay));
    repeat (npay) frame_q.push_back(8'($urandom));
    add_sums();
  endtask

  task automatic build_ack(input logic [7:0] id, input logic [7:0] ec, input logic [7:0] ei,
                           input int extra);
    start_frame(AckClass, id, 16'(2 + extra));
    frame_q.push_back(ec);
    frame_q.push_back(ei);
    repeat (extra) frame_q.push_back(8'($urandom));
    add_sums();
  endtask

  task automatic trim_frame(input int n);
    while (frame_q.size() > n) void'(frame_q.pop_back());
  endtask

  // Write every register, the ignored index too; the block must be idle
  task automatic set_config(input logic [7:0] cls, input logic [7:0] id, input logic ack);
    cfg_we_i <= 1'b1;
    cfg_index_i <= RegExpClass;
    cfg_wdata_i <= cls;
    @(posedge clk_i);
    cfg_index_i <= RegExpId;
    cfg_wdata_i <= id;
    @(posedge clk_i);
    cfg_index_i <= RegAckMode;
    cfg_wdata_i <= {7'd0, ack};
    @(posedge clk_i);
    cfg_index_i <= RegUnused;
    cfg_wdata_i <= 8'($urandom);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    cur_cls = cls;
    cur_id = id;
    cur_ack = ack;
    settings_used++;
  endtask

  // Hold off the sender until every status has been taken
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic well_formed();
    int r;
    r = $urandom_range(99);
    if (cur_ack) begin
      build_ack(r < 15 ? AckIdNack : AckIdAck,
                (r >= 15 && r < 30) ? 8'($urandom) : cur_cls,
                (r >= 15 && r < 30) ? 8'($urandom) : cur_id,
                ($urandom_range(3) == 0) ? $urandom_range(1, 8) : 0);
    end else begin
      build_frame(r < 85 ? cur_cls : 8'($urandom), r < 85 ? cur_id : 8'($urandom),
                  ($urandom_range(19) == 0) ? $urandom_range(13, 200) : $urandom_range(12));
    end
  endtask

  // Mostly well-formed frames, the rest corrupted, cut, padded or noise
  task automatic random_frame();
    int pick;
    int n;
    int idx;
    pick = $urandom_range(99);
    if (pick < 90) well_formed();
    if (pick >= 55 && pick < 70) begin
      idx = $urandom_range(frame_q.size() - 1);
      frame_q[idx] = frame_q[idx] ^ (8'h01 << $urandom_range(7));
    end else if (pick >= 70 && pick < 80) begin
      n = $urandom_range(1, 3);
      if ($urandom_range(1)) trim_frame(frame_q.size() - n);
      else repeat (n) frame_q.push_back(8'($urandom));
    end else if (pick >= 80 && pick < 90) begin
      n = $urandom_range(1, 7);
      trim_frame(n);
      if (cur_ack && n >= 4 && $urandom_range(1)) frame_q[3] = AckIdNack;
    end else if (pick >= 90) begin
      frame_q.delete();
      repeat ($urandom_range(1, 24)) frame_q.push_back(8'($urandom));
    end
    send_frame();
  endtask

  function automatic logic [7:0] pick_reg_value();
    int r;
    r = $urandom_range(99);
    if (r < 15) return 8'h00;
    if (r < 30) return 8'hFF;
    if (r < 40) return AckClass;
    return 8'($urandom);
  endfunction

  initial begin
    int ph;
    int k;
    int goal;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Plain check: good frames, each header fault, bad sums, length faults
    set_config(8'h06, 8'h01, 1'b0);
    build_frame(8'h06, 8'h01, 0);
    send_frame();
    build_frame(8'h06, 8'h01, 4);
    send_frame();
    build_frame(8'h06, 8'h01, 2);
    frame_q[0] = 8'hB4;
    send_frame();
    build_frame(8'h06, 8'h01, 2);
    frame_q[1] = 8'h63;
    send_frame();
    build_frame(8'h07, 8'h01, 3);
    send_frame();
    build_frame(8'h06, 8'h02, 3);
    send_frame();
    build_frame(8'h06, 8'h01, 5);
    frame_q[frame_q.size() - 2] = frame_q[frame_q.size() - 2] ^ 8'h80;
    send_frame();
    build_frame(8'h06, 8'h01, 5);
    frame_q[frame_q.size() - 1] = frame_q[frame_q.size() - 1] ^ 8'h01;
    send_frame();
    start_frame(8'h06, 8'h01, 16'd3);
    frame_q.push_back(8'hFF);
    frame_q.push_back(8'h00);
    add_sums();
    send_frame();
    start_frame(8'h06, 8'h01, 16'd6);
    repeat (6) frame_q.push_back(8'hFF);
    add_sums();
    send_frame();
    for (k = 1; k <= 7; k += 2) begin
      build_frame(8'h06, 8'h01, 0);
      trim_frame(k == 5 ? 4 : k);
      send_frame();
    end
    drain();

    // Register extremes
    set_config(8'h00, 8'h00, 1'b0);
    build_frame(8'h00, 8'h00, 1);
    send_frame();
    drain();
    set_config(8'hFF, 8'hFF, 1'b0);
    build_frame(8'hFF, 8'hFF, 2);
    send_frame();
    drain();

    // Acknowledge check: ack, nack, echo faults, a non-ack frame, short ack frames
    set_config(8'h06, 8'h01, 1'b1);
    build_ack(AckIdAck, 8'h06, 8'h01, 0);
    send_frame();
    build_ack(AckIdNack, 8'h06, 8'h01, 0);
    send_frame();
    build_ack(AckIdAck, 8'h07, 8'h01, 0);
    send_frame();
    build_ack(AckIdAck, 8'h06, 8'h02, 0);
    send_frame();
    build_frame(8'h06, 8'h01, 2);
    send_frame();
    build_ack(AckIdAck, 8'h06, 8'h01, 0);
    trim_frame(3);
    send_frame();
    build_ack(AckIdNack, 8'h06, 8'h01, 0);
    trim_frame(4);
    send_frame();
    build_ack(AckIdNack, 8'h06, 8'h01, 0);
    trim_frame(7);
    send_frame();
    build_ack(AckIdAck, 8'h06, 8'h01, 0);
    trim_frame(5);
    send_frame();
    drain();

    // Random frames under each idling mix, new settings between rounds
    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin snd_idle = 0;  rcv_stall = 0;  end
        1: begin snd_idle = 54; rcv_stall = 0;  end
        2: begin snd_idle = 0;  rcv_stall = 54; end
        default: begin snd_idle = 37; rcv_stall = 37; end
      endcase
      goal = bytes_sent + 240;
      while (bytes_sent < goal) begin
        set_config(pick_reg_value(), pick_reg_value(), 1'($urandom_range(1)));
        repeat ($urandom_range(4, 12)) random_frame();
        drain();
      end
    end

    $display("Covered %0d bytes in %0d frames over %0d register settings, with idle and",
             bytes_sent, frames_sent, settings_used);
    $display("stall mixes; statuses checked: %0d ok, %0d error, %0d too short.",
             ok_count, error_count, short_count);
    if (mismatch_count == 0) begin
      $display("gnss_binary_frame_checker_unit: match");
    end else begin
      $display("gnss_binary_frame_checker_unit: mismatch");
    end
    $finish;
  end

  // Give up if the run hangs
  initial begin
    #30000000;
    $display("gnss_binary_frame_checker_unit: mismatch");
    $finish;
  end

endmodule
